// File: hdl/lfukv_pkg.sv
// Shared types and constants for the LFU key-value cache.
// Used by lfukv_cell and lfu_cache_key_value_top; no dependencies.
package lfukv_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_COUNT_BITS = 16;

  localparam int              CAP_BITS  = 5;
  localparam logic [4:0]      CAP_RESET = 5'd16;
  localparam logic signed [31:0] NEG_ONE = -32'sd1;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Command broadcast to every cell of the row
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_TOUCH,
    CMD_REPLACE
  } cmd_kind_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } rsp_t;

endpackage

// File: hdl/lfukv_cell.sv
// One entry of the LFU key-value cache: key, value, use count, recency rank.
// Takes broadcast commands from the top level and passes the victim scan
// token to its neighbor each cycle. Depends on lfukv_pkg.
module lfukv_cell #(
  parameter int  IDX        = 0,
  parameter int  ENTRIES    = lfukv_pkg::DEF_ENTRIES,
  parameter int  COUNT_BITS = lfukv_pkg::DEF_COUNT_BITS,
  parameter type cmd_t      = logic,
  parameter type scan_t     = logic
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [31:0]       lookup_key,
  input  cmd_t                     cmd,
  input  scan_t                    scan_in,
  output scan_t                    scan_out,
  output logic                     match,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rank_out,
  output logic signed [31:0]       value_out
);

  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(IDX);

  logic                  valid;
  logic signed [31:0]    key;
  logic signed [31:0]    value;
  logic [COUNT_BITS-1:0] count;
  logic [IDX_BITS-1:0]   rank;
  scan_t                 scan_next;

  assign match     = valid && (key == lookup_key);
  assign rank_out  = rank;
  assign value_out = value;

  // Keep the lowest count; on equal counts keep the least recent entry.
  always_comb begin
    scan_next = scan_in;
    if (valid) begin
      if (!scan_in.found || (count < scan_in.count) ||
          ((count == scan_in.count) && (rank > scan_in.rank))) begin
        scan_next.found = 1'b1;
        scan_next.count = count;
        scan_next.rank  = rank;
        scan_next.idx   = MY_IDX;
        scan_next.key   = key;
      end
    end else if (!scan_in.free_found) begin
      scan_next.free_found = 1'b1;
      scan_next.free_idx   = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.kind)
        lfukv_pkg::CMD_TOUCH: begin
          if (valid) begin
            if (MY_IDX == cmd.tgt_idx) begin
              rank <= '0;
              if (count != '1) begin
                count <= count + 1'b1;
              end
              if (cmd.write_value) begin
                value <= cmd.value;
              end
            end else if (rank < cmd.ref_rank) begin
              rank <= rank + 1'b1;
            end
          end
        end
        lfukv_pkg::CMD_REPLACE: begin
          if (MY_IDX == cmd.slot_idx) begin
            valid <= 1'b1;
            key   <= cmd.key;
            value <= cmd.value;
            count <= COUNT_BITS'(1);
            rank  <= '0;
          end else if (cmd.evict && (MY_IDX == cmd.victim_idx)) begin
            valid <= 1'b0;
          end else if (valid) begin
            // entries behind the victim close the gap, then all age by one
            if (!(cmd.evict && (rank > cmd.victim_rank))) begin
              rank <= rank + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hdl/lfu_cache_key_value_top.sv
// Top level of the LFU key-value cache: control sequencer, response buffer
// and the row of lfukv_cell entries. Depends on lfukv_pkg and lfukv_cell.
//
// Fully associative key-value store with least-frequently-used replacement
// and least-recently-used tie break among equal use counts. Each accepted
// request first enters the lookup state, where all cells compare the key at
// once. A get or put that hits then passes the update state and the state
// that loads the output register; a put that hits while capacity is zero
// changes no cell. A miss that inserts nothing (a get, or a put while
// capacity is zero) goes from lookup straight to loading the output
// register. A put that misses runs the victim scan token down the row of
// ENTRIES cells, one cell per cycle, then places the entry and loads the
// output register. One request is in work at a time; the output register
// holds a finished result while the next request is taken, and the
// sequencer waits before loading the next result for as long as the
// previous one is still held.
// Valid bits clear at reset, so no clearing pass is needed.
module lfu_cache_key_value_top #(
  parameter int ENTRIES    = lfukv_pkg::DEF_ENTRIES,
  parameter int COUNT_BITS = lfukv_pkg::DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lfukv_pkg::req_t       in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lfukv_pkg::rsp_t       out_data,
  input  logic                  cfg_write,
  input  logic [lfukv_pkg::CAP_BITS-1:0] cfg_data
);

  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_BITS = $clog2(ENTRIES + 1);
  localparam int CMP_BITS = (OCC_BITS > lfukv_pkg::CAP_BITS) ? OCC_BITS : lfukv_pkg::CAP_BITS;

  typedef struct packed {
    lfukv_pkg::cmd_kind_t kind;
    logic                 write_value;
    logic [IDX_BITS-1:0]  tgt_idx;
    logic [IDX_BITS-1:0]  ref_rank;
    logic                 evict;
    logic [IDX_BITS-1:0]  victim_idx;
    logic [IDX_BITS-1:0]  victim_rank;
    logic [IDX_BITS-1:0]  slot_idx;
    logic signed [31:0]   key;
    logic signed [31:0]   value;
  } cmd_t;

  typedef struct packed {
    logic                  found;
    logic [COUNT_BITS-1:0] count;
    logic [IDX_BITS-1:0]   rank;
    logic [IDX_BITS-1:0]   idx;
    logic signed [31:0]    key;
    logic                  free_found;
    logic [IDX_BITS-1:0]   free_idx;
  } scan_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_HIT,
    S_SCAN,
    S_PLACE,
    S_DONE
  } state_t;

  state_t                state;
  lfukv_pkg::req_t       req;
  lfukv_pkg::rsp_t       rsp;
  logic [lfukv_pkg::CAP_BITS-1:0] cap_reg;
  logic [OCC_BITS-1:0]   occupied;
  logic [IDX_BITS-1:0]   hit_idx;
  logic [IDX_BITS-1:0]   hit_rank;
  logic signed [31:0]    hit_value;
  logic [IDX_BITS-1:0]   scan_cnt;

  logic [ENTRIES-1:0]    match;
  logic [IDX_BITS-1:0]   cell_rank  [ENTRIES];
  logic signed [31:0]    cell_value [ENTRIES];
  scan_t                 scan [ENTRIES+1];
  cmd_t                  cmd;

  logic                  hit_any;
  logic [IDX_BITS-1:0]   hit_idx_c;
  logic [IDX_BITS-1:0]   hit_rank_c;
  logic signed [31:0]    hit_value_c;
  logic [CMP_BITS-1:0]   cap_ext;
  logic [CMP_BITS-1:0]   cap_eff;
  logic                  cap_zero;
  logic                  full;
  logic                  place_evict;
  logic [IDX_BITS-1:0]   place_slot;
  scan_t                 tok;

  assign in_ready = (state == S_IDLE);
  assign scan[0]  = '0;
  assign tok      = scan[ENTRIES];

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      lfukv_cell #(
        .IDX        (gi),
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .cmd_t      (cmd_t),
        .scan_t     (scan_t)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .lookup_key (req.key),
        .cmd        (cmd),
        .scan_in    (scan[gi]),
        .scan_out   (scan[gi+1]),
        .match      (match[gi]),
        .rank_out   (cell_rank[gi]),
        .value_out  (cell_value[gi])
      );
    end
  endgenerate

  // At most one cell matches, so OR the selected fields together.
  always_comb begin
    hit_any     = |match;
    hit_idx_c   = '0;
    hit_rank_c  = '0;
    hit_value_c = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_idx_c   = hit_idx_c | IDX_BITS'(i);
        hit_rank_c  = hit_rank_c | cell_rank[i];
        hit_value_c = hit_value_c | cell_value[i];
      end
    end
  end

  always_comb begin
    cap_ext     = CMP_BITS'(cap_reg);
    cap_eff     = (cap_ext > CMP_BITS'(ENTRIES)) ? CMP_BITS'(ENTRIES) : cap_ext;
    cap_zero    = (cap_eff == '0);
    full        = (CMP_BITS'(occupied) >= cap_eff);
    place_evict = full && tok.found;
    // first free slot after the eviction: the lower of the free one and the victim
    if (tok.free_found && (!place_evict || (tok.free_idx < tok.idx))) begin
      place_slot = tok.free_idx;
    end else begin
      place_slot = tok.idx;
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.kind        = lfukv_pkg::CMD_NONE;
    cmd.key         = req.key;
    cmd.value       = req.value;
    cmd.tgt_idx     = hit_idx;
    cmd.ref_rank    = hit_rank;
    cmd.write_value = (req.opcode == lfukv_pkg::OP_PUT);
    cmd.evict       = place_evict;
    cmd.victim_idx  = tok.idx;
    cmd.victim_rank = tok.rank;
    cmd.slot_idx    = place_slot;
    if (state == S_HIT) begin
      if (!((req.opcode == lfukv_pkg::OP_PUT) && cap_zero)) begin
        cmd.kind = lfukv_pkg::CMD_TOUCH;
      end
    end else if (state == S_PLACE) begin
      cmd.kind = lfukv_pkg::CMD_REPLACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap_reg   <= lfukv_pkg::CAP_RESET;
      occupied  <= '0;
      out_valid <= 1'b0;
      scan_cnt  <= '0;
    end else begin
      if (cfg_write) begin
        cap_reg <= cfg_data;
      end
      // drop valid once taken, unless S_DONE loads the next result
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          hit_idx   <= hit_idx_c;
          hit_rank  <= hit_rank_c;
          hit_value <= hit_value_c;
          scan_cnt  <= '0;
          rsp.hit         <= hit_any;
          rsp.read_value  <= lfukv_pkg::NEG_ONE;
          rsp.evicted     <= 1'b0;
          rsp.evicted_key <= '0;
          if (hit_any) begin
            state <= S_HIT;
          end else if ((req.opcode == lfukv_pkg::OP_PUT) && !cap_zero) begin
            state <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_HIT: begin
          if (req.opcode == lfukv_pkg::OP_GET) begin
            rsp.read_value <= hit_value;
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          // let the token pass every cell of the row
          if (scan_cnt == IDX_BITS'(ENTRIES - 1)) begin
            state <= S_PLACE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_PLACE: begin
          rsp.evicted     <= place_evict;
          rsp.evicted_key <= place_evict ? tok.key : '0;
          if (!place_evict) begin
            occupied <= occupied + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= rsp;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
